// File: src/accel_vibration_pulse_classifier_assert.svh
`ifndef ACCEL_VIBRATION_PULSE_CLASSIFIER_ASSERT_SVH
`define ACCEL_VIBRATION_PULSE_CLASSIFIER_ASSERT_SVH

// Concurrent check on clk_i, held off while rst_ni is low.
`define AVPC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Same, but also checked during reset.
`define AVPC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// File: src/avpc_pkg.sv
package avpc_pkg;

  localparam int unsigned SampleW = 16;
  localparam int unsigned BaseW   = 24;
  localparam int unsigned DevW    = 16;
  localparam int unsigned CountW  = 8;
  localparam int unsigned ClassW  = 2;
  localparam int unsigned CfgW    = 16;
  localparam int unsigned CfgIdxW = 2;
  // 61*s + 195*b + 128 fits in 32 signed bits; 33 are used
  localparam int unsigned BlendW  = 33;

  localparam logic signed [BlendW-1:0] NewWeight = 33'sd61;
  localparam logic signed [BlendW-1:0] OldWeight = 33'sd195;
  localparam logic signed [BlendW-1:0] RoundBias = 33'sd128;

  localparam logic [CountW-1:0] CountMax = '1;

  localparam logic [CfgIdxW-1:0] RegPulseThreshold = 2'd0;
  localparam logic [CfgIdxW-1:0] RegPulseLenLimit  = 2'd1;
  localparam logic [CfgIdxW-1:0] RegStrongThresh   = 2'd2;

  localparam logic [DevW-1:0]   PulseThresholdRst = 16'd256;
  localparam logic [CountW-1:0] PulseLenLimitRst  = 8'd3;
  localparam logic [DevW-1:0]   StrongThreshRst   = 16'd102;

  localparam logic [ClassW-1:0] ClassNone   = 2'd0;
  localparam logic [ClassW-1:0] ClassLight  = 2'd1;
  localparam logic [ClassW-1:0] ClassStrong = 2'd2;

  typedef struct packed {
    logic upd;   // accepted, non-restart sample
    logic load;  // accepted restart sample
    logic loud;  // either axis over threshold
  } lane_ctrl_t;

  typedef struct packed {
    logic over;          // deviation above pulse threshold
    logic below_strong;  // stored peak under strong threshold
  } lane_status_t;

endpackage

// File: src/accel_vibration_pulse_classifier.sv
// An accepted input word's result reaches the output register in the cycle after accept.
// Throughput: one word per cycle unless a stalled result holds s_axis_tready low; all
// state (baselines, peaks, count) updates at accept, so lanes and merge are unpipelined.
// Reset (rst_ni low, asynchronous): baselines, peaks and count clear, no result pending,
// and the three configuration registers return to 256, 3 and 102.
module accel_vibration_pulse_classifier (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [avpc_pkg::CfgIdxW-1:0]         cfg_addr_i,
  input  logic [avpc_pkg::CfgW-1:0]            cfg_wdata_i,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  logic [31:0]                          s_axis_tdata,  // accel_x, accel_y
  input  logic                                 s_axis_tuser,  // restart
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  output logic [7:0]                           m_axis_tdata   // pulse_class, zero pad
);

  logic [avpc_pkg::DevW-1:0]   thresh_q;
  logic [avpc_pkg::CountW-1:0] limit_q;
  logic [avpc_pkg::DevW-1:0]   strong_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thresh_q <= avpc_pkg::PulseThresholdRst;
      limit_q  <= avpc_pkg::PulseLenLimitRst;
      strong_q <= avpc_pkg::StrongThreshRst;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        avpc_pkg::RegPulseThreshold: thresh_q <= cfg_wdata_i;
        avpc_pkg::RegPulseLenLimit:  limit_q  <= cfg_wdata_i[avpc_pkg::CountW-1:0];
        avpc_pkg::RegStrongThresh:   strong_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  avpc_pkg::lane_ctrl_t   ctrl;
  avpc_pkg::lane_status_t stat_x, stat_y;
  logic [avpc_pkg::ClassW-1:0] pulse_class;

  avpc_lane u_lane_x (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .sample_i           (s_axis_tdata[15:0]),
    .ctrl_i             (ctrl),
    .pulse_threshold_i  (thresh_q),
    .strong_threshold_i (strong_q),
    .status_o           (stat_x)
  );

  avpc_lane u_lane_y (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .sample_i           (s_axis_tdata[31:16]),
    .ctrl_i             (ctrl),
    .pulse_threshold_i  (thresh_q),
    .strong_threshold_i (strong_q),
    .status_o           (stat_y)
  );

  avpc_merge u_merge (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (s_axis_tvalid),
    .restart_i     (s_axis_tuser),
    .stat_x_i      (stat_x),
    .stat_y_i      (stat_y),
    .len_limit_i   (limit_q),
    .out_ready_i   (m_axis_tready),
    .in_ready_o    (s_axis_tready),
    .ctrl_o        (ctrl),
    .out_valid_o   (m_axis_tvalid),
    .pulse_class_o (pulse_class)
  );

  assign m_axis_tdata = {{(8 - avpc_pkg::ClassW){1'b0}}, pulse_class};

endmodule

// File: src/avpc_lane.sv
module avpc_lane (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic signed [avpc_pkg::SampleW-1:0] sample_i,
  input  avpc_pkg::lane_ctrl_t                ctrl_i,
  input  logic [avpc_pkg::DevW-1:0]           pulse_threshold_i,
  input  logic [avpc_pkg::DevW-1:0]           strong_threshold_i,
  output avpc_pkg::lane_status_t              status_o
);

  localparam int unsigned BW = avpc_pkg::BaseW;
  localparam int unsigned XW = avpc_pkg::BlendW;

  logic signed [BW-1:0] base_q, base_d;
  logic [avpc_pkg::DevW-1:0] peak_q, peak_d;

  logic signed [BW-1:0] s24;
  logic signed [BW:0]   diff;
  logic [BW:0]          abs_diff;
  logic [avpc_pkg::DevW-1:0] dev;
  logic signed [XW-1:0] blend_sum;
  logic signed [BW-1:0] blend;

  assign s24 = {sample_i, 8'h00};

  // deviation against the baseline before this sample's update
  assign diff     = $signed({s24[BW-1], s24}) - $signed({base_q[BW-1], base_q});
  assign abs_diff = diff[BW] ? (~diff + 1'b1) : diff;
  assign dev      = abs_diff[BW-1:8];

  // floor((61*s + 195*b + 128) / 256)
  assign blend_sum = avpc_pkg::NewWeight * $signed({{(XW-BW){s24[BW-1]}}, s24})
                   + avpc_pkg::OldWeight * $signed({{(XW-BW){base_q[BW-1]}}, base_q})
                   + avpc_pkg::RoundBias;
  assign blend = blend_sum[BW+7:8];

  always_comb begin
    base_d = base_q;
    peak_d = peak_q;
    if (ctrl_i.load) begin
      base_d = s24;
      peak_d = '0;
    end else if (ctrl_i.upd) begin
      base_d = blend;
      if (ctrl_i.loud && (peak_q < dev)) begin
        peak_d = dev;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= '0;
      peak_q <= '0;
    end else begin
      base_q <= base_d;
      peak_q <= peak_d;
    end
  end

  assign status_o.over         = dev > pulse_threshold_i;
  assign status_o.below_strong = peak_q < strong_threshold_i;

endmodule

// File: src/avpc_merge.sv
`include "accel_vibration_pulse_classifier_assert.svh"

module avpc_merge (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  input  logic                               restart_i,
  input  avpc_pkg::lane_status_t             stat_x_i,
  input  avpc_pkg::lane_status_t             stat_y_i,
  input  logic [avpc_pkg::CountW-1:0]        len_limit_i,
  input  logic                               out_ready_i,
  output logic                               in_ready_o,
  output avpc_pkg::lane_ctrl_t               ctrl_o,
  output logic                               out_valid_o,
  output logic [avpc_pkg::ClassW-1:0]        pulse_class_o
);

  logic [avpc_pkg::CountW-1:0] count_q, count_d;
  logic                        oval_q, oval_d;
  logic [avpc_pkg::ClassW-1:0] class_q, class_d;
  logic accept, loud, fire;

  assign in_ready_o = !oval_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign loud       = stat_x_i.over || stat_y_i.over;
  assign fire       = (count_q != '0) && (count_q > len_limit_i);

  assign ctrl_o.upd  = accept && !restart_i;
  assign ctrl_o.load = accept && restart_i;
  assign ctrl_o.loud = loud;

  always_comb begin
    count_d = count_q;
    class_d = class_q;
    oval_d  = oval_q && !out_ready_i;
    if (accept) begin
      oval_d  = 1'b1;
      class_d = avpc_pkg::ClassNone;
      if (restart_i) begin
        count_d = '0;
      end else if (loud) begin
        if (count_q != avpc_pkg::CountMax) begin
          count_d = count_q + 1'b1;
        end
      end else if (fire) begin
        count_d = '0;
        class_d = (stat_x_i.below_strong && stat_y_i.below_strong) ?
                  avpc_pkg::ClassLight : avpc_pkg::ClassStrong;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      oval_q  <= 1'b0;
    end else begin
      count_q <= count_d;
      oval_q  <= oval_d;
    end
  end

  // payload word, no reset needed
  always_ff @(posedge clk_i) begin
    class_q <= class_d;
  end

  assign out_valid_o   = oval_q;
  assign pulse_class_o = class_q;

  `AVPC_ASSERT(a_restart_quiet, accept && restart_i |=> oval_q && (class_q == avpc_pkg::ClassNone) && (count_q == '0), "restart word must report nothing and clear count")
  `AVPC_ASSERT(a_loud_count, accept && !restart_i && loud && (count_q != avpc_pkg::CountMax) |=> count_q == $past(count_q) + 1'b1, "loud word must raise count")
  `AVPC_ASSERT(a_pulse_clears, oval_q && (class_q != avpc_pkg::ClassNone) && $past(accept) |-> count_q == '0, "reported pulse must clear count")
  `AVPC_ASSERT(a_no_lost_word, oval_q && !out_ready_i |=> oval_q && $stable(class_q), "pending result dropped")

endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 100ps

module tb;

  logic                         clk_i = 1'b0;
  logic                         rst_ni = 1'b0;
  logic                         cfg_we_i = 1'b0;
  logic [avpc_pkg::CfgIdxW-1:0] cfg_addr_i = '0;
  logic [avpc_pkg::CfgW-1:0]    cfg_wdata_i = '0;
  logic                         s_axis_tvalid = 1'b0;
  logic                         s_axis_tready;
  logic [31:0]                  s_axis_tdata = '0;  // accel_x [15:0], accel_y [31:16]
  logic                         s_axis_tuser = 1'b0;  // restart
  logic                         m_axis_tvalid;
  logic                         m_axis_tready = 1'b0;
  logic [7:0]                   m_axis_tdata;       // pulse_class [1:0], zero pad [7:2]

  always #5 clk_i = ~clk_i;

  accel_vibration_pulse_classifier dut (.*);

  class pulse_scoreboard;
    logic [avpc_pkg::DevW-1:0]          thresh;
    logic [avpc_pkg::CountW-1:0]        len_limit;
    logic [avpc_pkg::DevW-1:0]          strong_thr;
    logic signed [avpc_pkg::BaseW-1:0]  base_x, base_y;
    logic [avpc_pkg::CountW-1:0]        loud_cnt;
    logic [avpc_pkg::DevW-1:0]          peak_x, peak_y;
    logic [avpc_pkg::ClassW-1:0]        class_q[$];
    int n_light, n_strong, n_restart, n_sat;

    function new();
      thresh     = avpc_pkg::PulseThresholdRst;
      len_limit  = avpc_pkg::PulseLenLimitRst;
      strong_thr = avpc_pkg::StrongThreshRst;
      base_x     = '0;
      base_y     = '0;
      loud_cnt   = '0;
      peak_x     = '0;
      peak_y     = '0;
    endfunction

    function void set_reg(logic [avpc_pkg::CfgIdxW-1:0] idx, logic [avpc_pkg::CfgW-1:0] val);
      case (idx)
        avpc_pkg::RegPulseThreshold: thresh = val[avpc_pkg::DevW-1:0];
        avpc_pkg::RegPulseLenLimit:  len_limit = val[avpc_pkg::CountW-1:0];
        avpc_pkg::RegStrongThresh:   strong_thr = val[avpc_pkg::DevW-1:0];
        default: ;
      endcase
    endfunction

    // |s - b| in Q16.0, fraction bits truncated
    static function logic [avpc_pkg::DevW-1:0] axis_dev(
        logic signed [avpc_pkg::BaseW-1:0] s,
        logic signed [avpc_pkg::BaseW-1:0] b);
      int d;
      d = int'(s) - int'(b);
      if (d < 0) d = -d;
      return d[avpc_pkg::DevW+7:8];
    endfunction

    // 61/256 new + 195/256 old, round half up
    static function logic signed [avpc_pkg::BaseW-1:0] ema(
        logic signed [avpc_pkg::BaseW-1:0] s,
        logic signed [avpc_pkg::BaseW-1:0] b);
      longint t;
      t = 64'sd61 * longint'(s) + 64'sd195 * longint'(b) + 64'sd128;
      t = t >>> 8;
      return t[avpc_pkg::BaseW-1:0];
    endfunction

    function void note_sample(logic signed [15:0] x, logic signed [15:0] y, logic restart);
      logic signed [avpc_pkg::BaseW-1:0] sx, sy;
      logic [avpc_pkg::DevW-1:0]         dx, dy;
      logic [avpc_pkg::ClassW-1:0]       cls;
      sx  = {x, 8'h00};
      sy  = {y, 8'h00};
      cls = avpc_pkg::ClassNone;
      if (restart) begin
        base_x   = sx;
        base_y   = sy;
        loud_cnt = '0;
        peak_x   = '0;
        peak_y   = '0;
        n_restart++;
      end else begin
        dx     = axis_dev(sx, base_x);
        dy     = axis_dev(sy, base_y);
        base_x = ema(sx, base_x);
        base_y = ema(sy, base_y);
        if (dx > thresh || dy > thresh) begin
          if (loud_cnt == avpc_pkg::CountMax) n_sat++;
          else loud_cnt++;
          if (peak_x < dx) peak_x = dx;
          if (peak_y < dy) peak_y = dy;
        end else if (loud_cnt != '0 && loud_cnt > len_limit) begin
          loud_cnt = '0;
          if (peak_x < strong_thr && peak_y < strong_thr) begin
            cls = avpc_pkg::ClassLight;
            n_light++;
          end else begin
            cls = avpc_pkg::ClassStrong;
            n_strong++;
          end
        end
      end
      class_q.push_back(cls);
    endfunction

    function bit check_result(logic [7:0] word, output string why);
      logic [avpc_pkg::ClassW-1:0] want;
      if (class_q.size() == 0) begin
        why = $sformatf("result word %02h with no sample outstanding", word);
        return 1'b0;
      end
      want = class_q.pop_front();
      if (word[avpc_pkg::ClassW-1:0] !== want) begin
        why = $sformatf("pulse_class %0d, expected %0d", word[avpc_pkg::ClassW-1:0], want);
        return 1'b0;
      end
      if (word[7:avpc_pkg::ClassW] !== '0) begin
        why = $sformatf("pad bits of result word %02h not zero", word);
        return 1'b0;
      end
      return 1'b1;
    endfunction
  endclass

  pulse_scoreboard sb = new();

  int n_errors = 0;
  int n_sent = 0;
  int n_settings = 1;
  int rx_wait = 0;
  bit tx_steady = 1'b0;
  bit rx_steady = 1'b0;

  task automatic report_mismatch(string why);
    n_errors++;
    if (n_errors <= 30) $display("%0t ns mismatch: %s", $realtime, why);
  endtask

  // monitor: both handshakes are sampled at the rising edge
  always @(posedge clk_i) begin
    string why;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready)
        sb.note_sample(s_axis_tdata[15:0], s_axis_tdata[31:16], s_axis_tuser);
      if (m_axis_tvalid && m_axis_tready) begin
        if (!sb.check_result(m_axis_tdata, why)) report_mismatch(why);
        rx_wait = rx_steady ? 0 : $urandom_range(0, 13);
      end
    end
  end

  // receiver back-pressure, one draw per result word
  always @(negedge clk_i) begin
    if (rx_wait > 0) begin
      m_axis_tready = 1'b0;
      rx_wait--;
    end else begin
      m_axis_tready = 1'b1;
    end
  end

  task automatic send_word(logic signed [15:0] x, logic signed [15:0] y, logic restart);
    int gap;
    gap = tx_steady ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tdata  = {y, x};
    s_axis_tuser  = restart;
    s_axis_tvalid = 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
    n_sent++;
  endtask

  task automatic write_reg(logic [avpc_pkg::CfgIdxW-1:0] idx, logic [avpc_pkg::CfgW-1:0] val);
    cfg_we_i    = 1'b1;
    cfg_addr_i  = idx;
    cfg_wdata_i = val;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    sb.set_reg(idx, val);
  endtask

  task automatic load_config(int thr, int lim, int strg);
    write_reg(avpc_pkg::RegPulseThreshold, avpc_pkg::CfgW'(thr));
    write_reg(avpc_pkg::RegPulseLenLimit, avpc_pkg::CfgW'(lim));
    write_reg(avpc_pkg::RegStrongThresh, avpc_pkg::CfgW'(strg));
    n_settings++;
  endtask

  // hold off until every outstanding result has come back
  task automatic settle();
    s_axis_tvalid = 1'b0;
    while (sb.class_q.size() != 0) @(negedge clk_i);
    repeat (3) @(negedge clk_i);
  endtask

  function automatic logic signed [15:0] clip16(int v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return v[15:0];
  endfunction

  function automatic int offset(bit loud, int th);
    int j;
    if (loud) j = th + 2 + int'($urandom_range(0, 400));
    else j = int'($urandom_range(0, 2 * th)) - th;
    if (loud && $urandom_range(0, 1)) j = -j;
    return j;
  endfunction

  // sample placed relative to the running baseline, loud or quiet
  task automatic send_near(bit loud);
    int th, jx, jy, axes;
    th   = int'(sb.thresh);
    axes = $urandom_range(0, 2);
    jx   = offset(loud && axes != 1, th);
    jy   = offset(loud && axes != 0, th);
    send_word(clip16(int'($signed(sb.base_x[avpc_pkg::BaseW-1:8])) + jx),
              clip16(int'($signed(sb.base_y[avpc_pkg::BaseW-1:8])) + jy), 1'b0);
  endtask

  task automatic burst(int len);
    repeat (len) send_near(1'b1);
    send_near(1'b0);
  endtask

  initial begin
    int ph, sel, stop, lim;
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // reset settings: quiet, restart at the rails, pulse under and over the limit
    send_word(16'sh0000, 16'sh0000, 1'b0);
    send_word(16'sh8000, 16'sh7fff, 1'b1);
    repeat (3) send_word(16'sh7fff, 16'sh8000, 1'b0);
    send_near(1'b0);
    burst(1);
    send_near(1'b0);
    send_word(16'sh5555, 16'shaaaa, 1'b0);
    settle();
    // threshold at full scale: a rail-to-rail swing is still quiet
    load_config(65535, 0, 65535);
    send_word(16'sh8000, 16'sh8000, 1'b1);
    send_word(16'sh7fff, 16'sh7fff, 1'b0);
    send_word(16'sh7fff, 16'sh8000, 1'b0);
    settle();
    // zero threshold and limit: any movement is loud, one word makes a light pulse
    write_reg(avpc_pkg::RegPulseThreshold, '0);
    send_word(16'shaaaa, 16'sh5555, 1'b1);
    burst(1);
    burst(2);
    send_word(16'sh0001, 16'shffff, 1'b0);

    ph = 0;
    while (n_sent < 1850) begin
      settle();
      ph++;
      tx_steady = ($urandom_range(0, 3) == 0);
      rx_steady = ($urandom_range(0, 3) == 0);
      if (ph == 4 || ph == 9) begin
        // long bursts up to and beyond count saturation
        lim = (ph == 4) ? 254 : 255;
        load_config($urandom_range(0, 300), lim, $urandom_range(0, 1200));
        send_word(clip16($urandom_range(0, 65535) - 32768),
                  clip16($urandom_range(0, 65535) - 32768), 1'b1);
        burst($urandom_range(256, 262));
        stop = n_sent + 20;
      end else begin
        sel = $urandom_range(0, 7);
        case (sel)
          0: load_config(65535, 0, 0);
          1: load_config(0, 0, 65535);
          2: load_config(avpc_pkg::PulseThresholdRst, avpc_pkg::PulseLenLimitRst,
                         avpc_pkg::StrongThreshRst);
          default: begin
            lim = $urandom_range(16, 1500);
            load_config(lim, $urandom_range(0, 8), $urandom_range(0, 2 * lim + 500));
          end
        endcase
        stop = n_sent + $urandom_range(40, 120);
      end
      while (n_sent < stop) begin
        case ($urandom_range(0, 9))
          0: send_word(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)), 1'b1);
          1, 2: send_word(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                          1'b0);
          default: burst($urandom_range(0, int'(sb.len_limit) + 3));
        endcase
      end
    end

    s_axis_tvalid = 1'b0;
    for (int i = 0; i < 500 && sb.class_q.size() != 0; i++) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
    if (sb.class_q.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", sb.class_q.size()));

    $display("%0d samples over %0d register settings, %0d of them restarts",
             n_sent, n_settings, sb.n_restart);
    $display("%0d light and %0d strong pulses, loud count held at saturation %0d times",
             sb.n_light, sb.n_strong, sb.n_sat);
    if (n_errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("FAIL");
    $finish;
  end

endmodule

// File: accel_vibration_pulse_classifier.f
+incdir+src
src/avpc_pkg.sv
src/avpc_lane.sv
src/avpc_merge.sv
src/accel_vibration_pulse_classifier.sv
tb/sv/tb.sv
